// ===== sv/priority_task_scheduler_assert.svh =====
// Assertion macros used by the scheduler RTL.
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define PTS_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked during reset as well.
`define PTS_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Types and codes shared by the priority task scheduler modules.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam logic [2:0] MODE_CREATE  = 3'd0;
   localparam logic [2:0] MODE_TICK    = 3'd1;
   localparam logic [2:0] MODE_DELAY   = 3'd2;
   localparam logic [2:0] MODE_SUSPEND = 3'd3;
   localparam logic [2:0] MODE_RESUME  = 3'd4;
   localparam logic [2:0] MODE_YIELD   = 3'd5;
   localparam logic [2:0] MODE_START   = 3'd6;

   localparam logic [1:0] TS_READY   = 2'd0;
   localparam logic [1:0] TS_RUN     = 2'd1;
   localparam logic [1:0] TS_BLOCK   = 2'd2;
   localparam logic [1:0] TS_SUSPEND = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_POOL_FULL   = 2'd1;
   localparam logic [1:0] STATUS_BAD_SLOT    = 2'd2;
   localparam logic [1:0] STATUS_NOT_STARTED = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  task_id;
      logic [1:0]  priority_req;
      logic [31:0] sleep_len;
   } req_type;

   typedef struct packed {
      logic [2:0]  running_task;
      logic        running_valid;
      logic        switched;
      logic [2:0]  new_task_id;
      logic [1:0]  status;
      logic [31:0] tick_value;
   } rsp_type;

   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_load_type;

endpackage

// ===== sv/pts_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// pts_rsp_reg
// Output register for the result channel; holds a beat while stalled.
// ----------------------------------------------------------------------------
module pts_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::rsp_load_type fill,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pts_pkg::rsp_type      rsp_data
);
   logic             valid_ff, valid_in;
   pts_pkg::rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      // The sequencer only loads when the register is empty.
      if (fill.load) begin
         valid_in = 1'b1;
         data_in  = fill.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// ===== sv/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Fixed-priority preemptive task scheduler with per-level LIFO ready lists.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one event per beat (create, tick, delay, suspend,
//   resume, yield, start). Each event gives exactly one beat on rsp with the
//   running slot, whether it changed, the slot of a new task, a status code
//   and the tick count after the event.
//   Events are handled one at a time by a small sequencer: req_stall is high
//   from acceptance until the result beat has been taken.
//   Create, resume, suspend of a task that is not running and ignored
//   events pass through the execute and done states to the result register.
//   Once started, a tick walks the used slots one per cycle, then the
//   ready lists are scanned one entry or one level per cycle; delay of the
//   running task, yield once started, suspend of the running task and a
//   first start also scan the ready lists before the result is formed.
//   A new event is accepted the cycle after the result beat has been taken.
//   When rsp_stall is high the result beat is held and no new event is
//   accepted until it has gone.
//   Reset clears all task slots, empties the ready lists, stops the scheduler
//   and zeroes the tick count; no result is pending afterwards.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
   parameter int TASK_SLOTS      = 8,
   parameter int PRIORITY_LEVELS = 4,
   parameter int DELAY_BITS      = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pts_pkg::rsp_type rsp_data
);
   localparam int SW = $clog2(TASK_SLOTS);
   localparam int LW = $clog2(PRIORITY_LEVELS);
   localparam logic [SW:0] NO_SLOT = (SW + 1)'(TASK_SLOTS);

   localparam logic [2:0] SQ_IDLE = 3'd0;
   localparam logic [2:0] SQ_EXEC = 3'd1;
   localparam logic [2:0] SQ_WALK = 3'd2;
   localparam logic [2:0] SQ_POP  = 3'd3;
   localparam logic [2:0] SQ_DONE = 3'd4;

   localparam logic [1:0] K_PICK    = 2'd0;
   localparam logic [1:0] K_PREEMPT = 2'd1;
   localparam logic [1:0] K_START   = 2'd2;

   logic [1:0]            st_ff   [TASK_SLOTS], st_in   [TASK_SLOTS];
   logic [LW-1:0]         pri_ff  [TASK_SLOTS], pri_in  [TASK_SLOTS];
   logic [DELAY_BITS-1:0] dly_ff  [TASK_SLOTS], dly_in  [TASK_SLOTS];
   logic [SW:0]           link_ff [TASK_SLOTS], link_in [TASK_SLOTS];
   logic                  q_ff    [TASK_SLOTS], q_in    [TASK_SLOTS];
   logic [SW:0]           head_ff [PRIORITY_LEVELS], head_in [PRIORITY_LEVELS];

   logic [2:0]       seq_ff, seq_in;
   logic [1:0]       cont_ff, cont_in;
   logic [SW-1:0]    cur_ff, cur_in;
   logic             started_ff, started_in;
   logic [SW:0]      used_ff, used_in;
   logic [31:0]      tick_ff, tick_in;
   logic [LW-1:0]    lvl_ff, lvl_in;
   logic [LW:0]      min_ff, min_in;
   logic [SW-1:0]    walk_ff, walk_in;
   pts_pkg::req_type req_ff, req_in;
   logic             was_valid_ff, was_valid_in;
   logic [SW-1:0]    was_slot_ff, was_slot_in;
   logic [1:0]       status_ff, status_in;
   logic [SW-1:0]    newid_ff, newid_in;

   pts_pkg::rsp_load_type fill;
   logic                  accept;

   assign req_stall = (seq_ff != SQ_IDLE) || rsp_valid;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      logic [SW-1:0]         c, s, t, tid;
      logic [LW-1:0]         p;
      logic [SW:0]           h;
      logic [DELAY_BITS-1:0] d;
      logic [63:0]           tid_wide, cur_wide, new_wide;
      logic                  now_valid;

      st_in = st_ff; pri_in = pri_ff; dly_in = dly_ff; link_in = link_ff;
      q_in = q_ff; head_in = head_ff;
      seq_in = seq_ff; cont_in = cont_ff; cur_in = cur_ff;
      started_in = started_ff; used_in = used_ff; tick_in = tick_ff;
      lvl_in = lvl_ff; min_in = min_ff; walk_in = walk_ff; req_in = req_ff;
      was_valid_in = was_valid_ff; was_slot_in = was_slot_ff;
      status_in = status_ff; newid_in = newid_ff;
      fill = '0;

      c        = cur_ff;
      tid_wide = 64'(req_ff.task_id);
      tid      = tid_wide[SW-1:0];
      d        = req_ff.sleep_len[DELAY_BITS-1:0];
      s        = used_ff[SW-1:0];
      t        = '0;
      h        = '0;
      p        = '0;
      now_valid = 1'b0;
      cur_wide = '0;
      new_wide = '0;

      unique case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               was_valid_in = started_ff && (st_ff[cur_ff] == pts_pkg::TS_RUN);
               was_slot_in  = cur_ff;
               status_in    = pts_pkg::STATUS_OK;
               newid_in     = '0;
               seq_in       = SQ_EXEC;
            end
         end
         SQ_EXEC: begin
            seq_in  = SQ_DONE;
            min_in  = '0;
            lvl_in  = LW'(PRIORITY_LEVELS - 1);
            cont_in = K_PICK;
            unique case (req_ff.mode)
               pts_pkg::MODE_CREATE: begin
                  if (used_ff >= (SW + 1)'(TASK_SLOTS)) begin
                     status_in = pts_pkg::STATUS_POOL_FULL;
                  end else begin
                     if (32'(req_ff.priority_req) < 32'(PRIORITY_LEVELS)) begin
                        p = LW'(req_ff.priority_req);
                     end else begin
                        p = LW'(PRIORITY_LEVELS - 1);
                     end
                     pri_in[s]  = p;
                     st_in[s]   = pts_pkg::TS_READY;
                     dly_in[s]  = '0;
                     link_in[s] = head_ff[p];
                     head_in[p] = {1'b0, s};
                     q_in[s]    = 1'b1;
                     newid_in   = s;
                     used_in    = used_ff + 1'b1;
                  end
               end
               pts_pkg::MODE_TICK: begin
                  tick_in = tick_ff + 32'd1;
                  if (!started_ff) begin
                     status_in = pts_pkg::STATUS_NOT_STARTED;
                  end else if (used_ff == '0) begin
                     // No slots to walk: go straight to the ready-list scan.
                     if (st_ff[c] == pts_pkg::TS_RUN) begin
                        min_in  = {1'b0, pri_ff[c]} + 1'b1;
                        cont_in = K_PREEMPT;
                     end
                     seq_in = SQ_POP;
                  end else begin
                     walk_in = '0;
                     seq_in  = SQ_WALK;
                  end
               end
               pts_pkg::MODE_DELAY: begin
                  if (!started_ff) begin
                     status_in = pts_pkg::STATUS_NOT_STARTED;
                  end else if (st_ff[c] == pts_pkg::TS_RUN) begin
                     if (d == '0) begin
                        st_in[c] = pts_pkg::TS_READY;
                        if (!q_ff[c]) begin
                           link_in[c]          = head_ff[pri_ff[c]];
                           head_in[pri_ff[c]]  = {1'b0, c};
                           q_in[c]             = 1'b1;
                        end
                     end else begin
                        st_in[c]  = pts_pkg::TS_BLOCK;
                        dly_in[c] = d;
                     end
                     seq_in = SQ_POP;
                  end
               end
               pts_pkg::MODE_SUSPEND: begin
                  if (tid_wide >= 64'(used_ff)) begin
                     status_in = pts_pkg::STATUS_BAD_SLOT;
                  end else begin
                     st_in[tid] = pts_pkg::TS_SUSPEND;
                     if (st_ff[tid] == pts_pkg::TS_RUN && started_ff && tid == c) begin
                        seq_in = SQ_POP;
                     end
                  end
               end
               pts_pkg::MODE_RESUME: begin
                  if (tid_wide >= 64'(used_ff)) begin
                     status_in = pts_pkg::STATUS_BAD_SLOT;
                  end else if (st_ff[tid] == pts_pkg::TS_SUSPEND) begin
                     st_in[tid] = pts_pkg::TS_READY;
                     if (!q_ff[tid]) begin
                        link_in[tid]         = head_ff[pri_ff[tid]];
                        head_in[pri_ff[tid]] = {1'b0, tid};
                        q_in[tid]            = 1'b1;
                     end
                  end
               end
               pts_pkg::MODE_YIELD: begin
                  if (!started_ff) begin
                     status_in = pts_pkg::STATUS_NOT_STARTED;
                  end else begin
                     if (st_ff[c] == pts_pkg::TS_RUN) begin
                        st_in[c] = pts_pkg::TS_READY;
                        if (!q_ff[c]) begin
                           link_in[c]         = head_ff[pri_ff[c]];
                           head_in[pri_ff[c]] = {1'b0, c};
                           q_in[c]            = 1'b1;
                        end
                     end
                     seq_in = SQ_POP;
                  end
               end
               pts_pkg::MODE_START: begin
                  if (!started_ff) begin
                     cont_in = K_START;
                     seq_in  = SQ_POP;
                  end
               end
               default: begin
               end
            endcase
         end
         SQ_WALK: begin
            if (st_ff[walk_ff] == pts_pkg::TS_BLOCK && dly_ff[walk_ff] != '0) begin
               dly_in[walk_ff] = dly_ff[walk_ff] - 1'b1;
               if (dly_ff[walk_ff] == DELAY_BITS'(1)) begin
                  st_in[walk_ff] = pts_pkg::TS_READY;
                  if (!q_ff[walk_ff]) begin
                     link_in[walk_ff]         = head_ff[pri_ff[walk_ff]];
                     head_in[pri_ff[walk_ff]] = {1'b0, walk_ff};
                     q_in[walk_ff]            = 1'b1;
                  end
               end
            end
            if ({1'b0, walk_ff} == used_ff - 1'b1) begin
               // The current slot is never touched by the walk unless blocked.
               if (st_ff[c] == pts_pkg::TS_RUN) begin
                  min_in  = {1'b0, pri_ff[c]} + 1'b1;
                  cont_in = K_PREEMPT;
               end
               seq_in = SQ_POP;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         SQ_POP: begin
            if (min_ff >= (LW + 1)'(PRIORITY_LEVELS)) begin
               seq_in = SQ_DONE;
            end else begin
               h = head_ff[lvl_ff];
               if (h != NO_SLOT) begin
                  t               = h[SW-1:0];
                  head_in[lvl_ff] = link_ff[t];
                  q_in[t]         = 1'b0;
                  // Entries that are no longer ready are dropped here.
                  if (st_ff[t] == pts_pkg::TS_READY) begin
                     seq_in   = SQ_DONE;
                     cur_in   = t;
                     st_in[t] = pts_pkg::TS_RUN;
                     if (cont_ff == K_START) begin
                        started_in = 1'b1;
                     end else if (cont_ff == K_PREEMPT) begin
                        st_in[c]           = pts_pkg::TS_READY;
                        link_in[c]         = head_ff[pri_ff[c]];
                        head_in[pri_ff[c]] = {1'b0, c};
                        q_in[c]            = 1'b1;
                     end
                  end
               end else if ({1'b0, lvl_ff} == min_ff) begin
                  seq_in = SQ_DONE;
                  if (cont_ff == K_START) begin
                     status_in = pts_pkg::STATUS_NOT_STARTED;
                  end
               end else begin
                  lvl_in = lvl_ff - 1'b1;
               end
            end
         end
         SQ_DONE: begin
            now_valid = started_ff && (st_ff[cur_ff] == pts_pkg::TS_RUN);
            cur_wide  = 64'(cur_ff);
            new_wide  = 64'(newid_ff);
            fill.load = 1'b1;
            fill.data.running_task  = now_valid ? cur_wide[2:0] : 3'd0;
            fill.data.running_valid = now_valid;
            fill.data.switched      = (was_valid_ff != now_valid) ||
                                      (now_valid && was_slot_ff != cur_ff);
            fill.data.new_task_id   = new_wide[2:0];
            fill.data.status        = status_ff;
            fill.data.tick_value    = tick_ff;
            seq_in = SQ_IDLE;
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            st_ff[i]  <= pts_pkg::TS_READY;
            dly_ff[i] <= '0;
            q_ff[i]   <= 1'b0;
         end
         for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            head_ff[i] <= NO_SLOT;
         end
         seq_ff     <= SQ_IDLE;
         cur_ff     <= '0;
         started_ff <= 1'b0;
         used_ff    <= '0;
         tick_ff    <= '0;
      end else begin
         st_ff      <= st_in;
         dly_ff     <= dly_in;
         q_ff       <= q_in;
         head_ff    <= head_in;
         seq_ff     <= seq_in;
         cur_ff     <= cur_in;
         started_ff <= started_in;
         used_ff    <= used_in;
         tick_ff    <= tick_in;
      end
      pri_ff       <= pri_in;
      link_ff      <= link_in;
      cont_ff      <= cont_in;
      lvl_ff       <= lvl_in;
      min_ff       <= min_in;
      walk_ff      <= walk_in;
      req_ff       <= req_in;
      was_valid_ff <= was_valid_in;
      was_slot_ff  <= was_slot_in;
      status_ff    <= status_in;
      newid_ff     <= newid_in;
   end

   pts_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .fill      (fill),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`include "priority_task_scheduler_assert.svh"

   `PTS_CHECK(a_accept_starts_work, accept |=> (seq_ff == SQ_EXEC), "event not taken up")
   `PTS_CHECK(a_done_fills_rsp, (seq_ff == SQ_DONE) |=> rsp_valid, "result beat missing")
   `PTS_CHECK(a_running_needs_start, (rsp_valid && rsp_data.running_valid) |-> started_ff, "running before start")
   `PTS_CHECK(a_used_bound, used_ff <= (SW + 1)'(TASK_SLOTS), "slot count overflow")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the priority task scheduler. A directed table
// of events is sent first, then random event sequences. Every accepted event
// is run through a behavioural scheduler model, and each result beat is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 8;
   localparam int LEVELS      = 4;
   localparam int RAND_EVENTS = 500;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [3:0] NO_SLOT = 4'd8;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pts_pkg::rsp_type rsp_data;

   priority_task_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Scheduler model state.
   logic [1:0]  task_state [SLOTS];
   logic [1:0]  task_prio  [SLOTS];
   logic [31:0] task_wait  [SLOTS];
   logic [3:0]  task_next  [SLOTS];
   logic        task_linked[SLOTS];
   logic [3:0]  level_head [LEVELS];
   logic [2:0]  cur_task;
   logic        sched_on;
   int          tasks_made;
   logic [31:0] ticks_seen;

   pts_pkg::rsp_type rsp_due[$];
   int      fail_count = 0;
   int      beats_taken = 0;

   function automatic void model_reset();
      for (int i = 0; i < SLOTS; i++) begin
         task_state[i] = pts_pkg::TS_READY;
         task_prio[i] = '0;
         task_wait[i] = '0;
         task_next[i] = '0;
         task_linked[i] = 1'b0;
      end
      for (int l = 0; l < LEVELS; l++) level_head[l] = NO_SLOT;
      cur_task = '0;
      sched_on = 1'b0;
      tasks_made = 0;
      ticks_seen = '0;
   endfunction

   function automatic void link_ready(int s);
      task_next[s] = level_head[task_prio[s]];
      level_head[task_prio[s]] = 4'(s);
      task_linked[s] = 1'b1;
   endfunction

   // Takes the best ready task from levels at or above min_lvl; stale entries
   // are dropped on the way.
   function automatic logic [3:0] take_best(int min_lvl);
      int t;
      for (int l = LEVELS - 1; l >= min_lvl; l--) begin
         while (level_head[l] != NO_SLOT) begin
            t = level_head[l];
            level_head[l] = task_next[t];
            task_linked[t] = 1'b0;
            if (task_state[t] == pts_pkg::TS_READY) return 4'(t);
         end
      end
      return NO_SLOT;
   endfunction

   function automatic void run_best();
      logic [3:0] t;
      t = take_best(0);
      if (t != NO_SLOT) begin
         cur_task = t[2:0];
         task_state[t] = pts_pkg::TS_RUN;
      end
   endfunction

   function automatic void give_way();
      if (task_state[cur_task] == pts_pkg::TS_RUN) begin
         task_state[cur_task] = pts_pkg::TS_READY;
         if (!task_linked[cur_task]) link_ready(cur_task);
      end
      run_best();
   endfunction

   function automatic pts_pkg::rsp_type sched_step(pts_pkg::req_type ev);
      pts_pkg::rsp_type r;
      logic       was_on, now_on;
      logic [2:0] was_task;
      logic [3:0] t;
      r = '0;
      was_on = sched_on && task_state[cur_task] == pts_pkg::TS_RUN;
      was_task = cur_task;
      case (ev.mode)
         pts_pkg::MODE_CREATE: begin
            if (tasks_made >= SLOTS) begin
               r.status = pts_pkg::STATUS_POOL_FULL;
            end else begin
               task_prio[tasks_made] = ev.priority_req;
               task_state[tasks_made] = pts_pkg::TS_READY;
               task_wait[tasks_made] = '0;
               link_ready(tasks_made);
               r.new_task_id = 3'(tasks_made);
               tasks_made++;
            end
         end
         pts_pkg::MODE_TICK: begin
            ticks_seen++;
            if (!sched_on) begin
               r.status = pts_pkg::STATUS_NOT_STARTED;
            end else begin
               for (int i = 0; i < tasks_made; i++) begin
                  if (task_state[i] == pts_pkg::TS_BLOCK && task_wait[i] != 0) begin
                     task_wait[i]--;
                     if (task_wait[i] == 0) begin
                        task_state[i] = pts_pkg::TS_READY;
                        if (!task_linked[i]) link_ready(i);
                     end
                  end
               end
               if (task_state[cur_task] == pts_pkg::TS_RUN) begin
                  t = take_best(int'(task_prio[cur_task]) + 1);
                  if (t != NO_SLOT) begin
                     task_state[cur_task] = pts_pkg::TS_READY;
                     link_ready(cur_task);
                     cur_task = t[2:0];
                     task_state[t] = pts_pkg::TS_RUN;
                  end
               end else begin
                  run_best();
               end
            end
         end
         pts_pkg::MODE_DELAY: begin
            if (!sched_on) begin
               r.status = pts_pkg::STATUS_NOT_STARTED;
            end else if (task_state[cur_task] == pts_pkg::TS_RUN) begin
               if (ev.sleep_len == 0) begin
                  give_way();
               end else begin
                  task_state[cur_task] = pts_pkg::TS_BLOCK;
                  task_wait[cur_task] = ev.sleep_len;
                  run_best();
               end
            end
         end
         pts_pkg::MODE_SUSPEND: begin
            if (ev.task_id >= tasks_made) begin
               r.status = pts_pkg::STATUS_BAD_SLOT;
            end else begin
               t = {1'b0, ev.task_id};
               if (task_state[t] == pts_pkg::TS_RUN && sched_on &&
                   ev.task_id == cur_task) begin
                  task_state[t] = pts_pkg::TS_SUSPEND;
                  run_best();
               end else begin
                  task_state[t] = pts_pkg::TS_SUSPEND;
               end
            end
         end
         pts_pkg::MODE_RESUME: begin
            if (ev.task_id >= tasks_made) begin
               r.status = pts_pkg::STATUS_BAD_SLOT;
            end else if (task_state[ev.task_id] == pts_pkg::TS_SUSPEND) begin
               task_state[ev.task_id] = pts_pkg::TS_READY;
               if (!task_linked[ev.task_id]) link_ready(ev.task_id);
            end
         end
         pts_pkg::MODE_YIELD: begin
            if (!sched_on) r.status = pts_pkg::STATUS_NOT_STARTED;
            else give_way();
         end
         pts_pkg::MODE_START: begin
            if (!sched_on) begin
               t = take_best(0);
               if (t != NO_SLOT) begin
                  sched_on = 1'b1;
                  cur_task = t[2:0];
                  task_state[t] = pts_pkg::TS_RUN;
               end else begin
                  r.status = pts_pkg::STATUS_NOT_STARTED;
               end
            end
         end
         default: ;
      endcase
      now_on = sched_on && task_state[cur_task] == pts_pkg::TS_RUN;
      r.running_task = now_on ? cur_task : 3'd0;
      r.running_valid = now_on;
      r.switched = (was_on != now_on) || (now_on && was_task != cur_task);
      r.tick_value = ticks_seen;
      return r;
   endfunction

   function automatic pts_pkg::req_type mk_ev(logic [2:0] m, logic [2:0] id = '0,
                                              logic [1:0] p = '0, logic [31:0] d = '0);
      pts_pkg::req_type e;
      e.mode = m;
      e.task_id = id;
      e.priority_req = p;
      e.sleep_len = d;
      return e;
   endfunction

   function automatic pts_pkg::rsp_type mk_rsp(logic [2:0] run, logic vld, logic sw,
                                               logic [2:0] nid, logic [1:0] st,
                                               logic [31:0] tc);
      pts_pkg::rsp_type r;
      r.running_task = run;
      r.running_valid = vld;
      r.switched = sw;
      r.new_task_id = nid;
      r.status = st;
      r.tick_value = tc;
      return r;
   endfunction

   // Mostly scheduler traffic once started, with short sleeps so that blocked
   // tasks wake up again; long and zero sleeps now and then.
   function automatic pts_pkg::req_type random_event();
      int pick, dsel;
      logic [31:0] d;
      pick = $urandom_range(0, 99);
      dsel = $urandom_range(0, 9);
      d = (dsel == 0) ? 32'd0 : (dsel < 8) ? 32'($urandom_range(1, 4)) : $urandom;
      return mk_ev(pick < 35 ? pts_pkg::MODE_TICK : pick < 52 ? pts_pkg::MODE_DELAY :
                   pick < 64 ? pts_pkg::MODE_SUSPEND : pick < 80 ? pts_pkg::MODE_RESUME :
                   pick < 90 ? pts_pkg::MODE_YIELD : pick < 94 ? pts_pkg::MODE_CREATE :
                   pick < 97 ? pts_pkg::MODE_START : MODE_UNUSED,
                   3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), d);
   endfunction

   typedef struct {
      pts_pkg::req_type ev;
      bit               typed;
      pts_pkg::rsp_type want;
   } stim_row_type;

   stim_row_type plan[$];
   int burst_left = 0;

   task automatic send_event(pts_pkg::req_type ev, bit typed, pts_pkg::rsp_type want);
      pts_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (req_stall);
      predicted = sched_step(ev);
      rsp_due.push_back(typed ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
   endtask

   initial begin
      model_reset();
      plan.push_back('{mk_ev(pts_pkg::MODE_TICK), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_NOT_STARTED, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_YIELD), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_NOT_STARTED, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_DELAY, 0, 0, 5), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_NOT_STARTED, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_START), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_NOT_STARTED, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_SUSPEND, 0), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_BAD_SLOT, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_RESUME, 7), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_BAD_SLOT, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 0, 3), 1,
                       mk_rsp(0, 0, 0, 0, pts_pkg::STATUS_OK, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 0, 0), 1,
                       mk_rsp(0, 0, 0, 1, pts_pkg::STATUS_OK, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_START), 1,
                       mk_rsp(0, 1, 1, 0, pts_pkg::STATUS_OK, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_START), 1,
                       mk_rsp(0, 1, 0, 0, pts_pkg::STATUS_OK, 1)});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 0, 2), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_DELAY, 0, 0, 0), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_DELAY, 0, 0, 32'hFFFF_FFFF), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 0, 1), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_SUSPEND, 2), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_RESUME, 2), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_RESUME, 1), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_TICK), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_YIELD), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_DELAY, 0, 0, 2), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 5, 3), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 2, 2), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 7, 1), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE, 0, 0), 0, '0});
      plan.push_back('{mk_ev(pts_pkg::MODE_CREATE), 0, '0});
      plan.push_back('{mk_ev(MODE_UNUSED, 7, 3, 32'hFFFF_FFFF), 0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) send_event(plan[i].ev, plan[i].typed, plan[i].want);
      for (int n = 0; n < RAND_EVENTS; n++) send_event(random_event(), 0, '0);
      req_valid <= 1'b0;
      wait (rsp_due.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Result side: its own stall pattern, plus one long hold-off part way in
   // while the sender keeps offering events.
   int  stall_left = 0;
   int  quiet_left = 0;
   int  hold_left = 0;
   bit  held_once = 1'b0;

   always @(posedge clock) begin
      pts_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_taken++;
            if (rsp_due.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = rsp_due.pop_front();
               if (rsp_data.running_task !== want.running_task) begin
                  $error("running_task expected %0d actual %0d",
                         want.running_task, rsp_data.running_task);
                  fail_count++;
               end
               if (rsp_data.running_valid !== want.running_valid) begin
                  $error("running_valid expected %0d actual %0d",
                         want.running_valid, rsp_data.running_valid);
                  fail_count++;
               end
               if (rsp_data.switched !== want.switched) begin
                  $error("switched expected %0d actual %0d", want.switched, rsp_data.switched);
                  fail_count++;
               end
               if (rsp_data.new_task_id !== want.new_task_id) begin
                  $error("new_task_id expected %0d actual %0d",
                         want.new_task_id, rsp_data.new_task_id);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.tick_value !== want.tick_value) begin
                  $error("tick_value expected %0d actual %0d",
                         want.tick_value, rsp_data.tick_value);
                  fail_count++;
               end
            end
         end
         if (!held_once && beats_taken >= 250) begin
            held_once = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) quiet_left = $urandom_range(20, 80);
            else stall_left = $urandom_range(0, 10);
         end
      end
   end

   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
